/* src/skpl_pkg.sv */
// Shared constants, codes and types of the sorted key priority list.
`default_nettype none

package skpl_pkg;

  // Sizes of the list and of its fields.
  localparam int CAPACITY    = 16;
  localparam int KEY_BITS    = 32;
  localparam int ITEM_BITS   = 32;
  localparam int FUNC_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int ADDR_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ENTRY_BITS  = KEY_BITS + ITEM_BITS;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_DATA_BITS  = ((ITEM_BITS + KEY_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((ITEM_BITS + KEY_BITS + COUNT_BITS + 7) / 8) * 8;

  // Request codes.
  localparam logic [FUNC_BITS-1:0] FN_PREPEND   = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_APPEND    = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_SORTED    = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_REM_FIRST = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_REM_KEY   = 3'd4;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

  // Results of the shared key unit.
  typedef struct packed {
    logic [KEY_BITS-1:0] step;   // entry key plus or minus one
    logic                below;  // request key is less than entry key
    logic                equal;  // request key equals entry key
  } alu_res_t;

endpackage

`default_nettype wire

/* src/sorted_key_priority_list.sv */
// Top level of the sorted key priority list: sequencer, entry store and key unit.
//
//  Channel | Direction | Handshake             | Contents (low bits first)
//  in_     | slave     | in_tvalid/in_tready   | tuser: func; tdata: item_in, key_in
//  out_    | master    | out_tvalid/out_tready | tuser: status;
//          |           |                       | tdata: item_out, key_out, entry_count
//  cfg_    | write     | cfg_wr_en             | cfg_wr_data: base_key
//
// A request steps through accept, a scan of one entry per step, a move of one entry per step,
// the placing of a new entry and the presentation of the result.
// The entry RAM has a single read port: every scan and move step reads one entry.
// Reset (rst_n low, synchronous) empties the list and sets the base key to zero.
// A result waits in the output register until taken; no new word is taken meanwhile.
`default_nettype none

module sorted_key_priority_list
  import skpl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Request stream.
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [FUNC_BITS-1:0]     in_tuser,     // [2:0] func
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,     // [31:0] item_in, [63:32] key_in
  // Result stream.
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic      [STATUS_BITS-1:0]   out_tuser,    // [1:0] status
  output logic      [OUT_DATA_BITS-1:0] out_tdata,    // [31:0] item_out, [63:32] key_out,
                                                      // [68:64] entry_count, rest zero
  // Configuration.
  input  wire logic                     cfg_wr_en,
  input  wire logic [KEY_BITS-1:0]      cfg_wr_data   // base_key
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_BITS-1:0]  occ_r, occ_nxt;
  logic [KEY_BITS-1:0]    base_key_r;
  logic [FUNC_BITS-1:0]   func_r, func_nxt;
  logic [ITEM_BITS-1:0]   item_r, item_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [ADDR_BITS-1:0]   idx_r, idx_nxt;
  logic [ADDR_BITS-1:0]   pos_r, pos_nxt;
  logic [KEY_BITS-1:0]    new_key_r, new_key_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic [ITEM_BITS-1:0]   item_out_r, item_out_nxt;
  logic [KEY_BITS-1:0]    key_out_r, key_out_nxt;

  logic                   in_accept;
  logic [ITEM_BITS-1:0]   in_item;
  logic [KEY_BITS-1:0]    in_key;
  logic                   is_insert;
  logic                   list_empty;
  logic                   list_full;
  logic                   scan_last;
  logic [ADDR_BITS-1:0]   last_addr;

  logic                   ram_wr_en;
  logic [ADDR_BITS-1:0]   ram_wr_addr;
  logic [ENTRY_BITS-1:0]  ram_wr_data;
  logic [ENTRY_BITS-1:0]  ram_rd_data;
  logic [KEY_BITS-1:0]    rd_key;
  logic [ITEM_BITS-1:0]   rd_item;
  alu_res_t               alu_res;

  // Request fields.
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_item   = in_tdata[ITEM_BITS-1:0];
  assign in_key    = in_tdata[ITEM_BITS +: KEY_BITS];

  // Entry store: key in the upper bits, item in the lower bits.
  skpl_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (idx_nxt),
    .rd_data (ram_rd_data)
  );

  assign rd_key  = ram_rd_data[ITEM_BITS +: KEY_BITS];
  assign rd_item = ram_rd_data[ITEM_BITS-1:0];

  // Shared key unit works on the entry that was read last.
  skpl_key_alu u_alu (
    .entry_key (rd_key),
    .req_key   (key_r),
    .dec       (func_r == FN_PREPEND),
    .res       (alu_res)
  );

  // Helper conditions for the sequencer.
  assign is_insert  = (func_r == FN_PREPEND) || (func_r == FN_APPEND) ||
                      (func_r == FN_SORTED);
  assign list_empty = (occ_r == '0);
  assign list_full  = (occ_r == COUNT_BITS'(CAPACITY));
  assign scan_last  = (COUNT_BITS'(idx_r) + COUNT_BITS'(1) == occ_r);
  assign last_addr  = ADDR_BITS'(occ_r - COUNT_BITS'(1));

  // Sequencer: scan for the position or the entry, move entries one per cycle, then place or finish.
  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    func_nxt     = func_r;
    item_nxt     = item_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    new_key_nxt  = new_key_r;
    status_nxt   = status_r;
    item_out_nxt = item_out_r;
    key_out_nxt  = key_out_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = idx_r;
    ram_wr_data  = ram_rd_data;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          func_nxt     = in_tuser;
          item_nxt     = in_item;
          key_nxt      = in_key;
          idx_nxt      = '0;
          pos_nxt      = '0;
          item_out_nxt = '0;
          key_out_nxt  = '0;
          case (in_tuser)
            FN_PREPEND, FN_APPEND, FN_SORTED: begin
              if (list_full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (list_empty) begin
                new_key_nxt = (in_tuser == FN_SORTED) ? in_key : base_key_r;
                state_nxt   = S_WRITE;
              end else begin
                if (in_tuser == FN_APPEND) begin
                  idx_nxt = last_addr;
                end
                state_nxt = S_SCAN;
              end
            end
            FN_REM_FIRST, FN_REM_KEY: begin
              if (list_empty) begin
                status_nxt = ST_MISS;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_MISS;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (func_r)
          FN_PREPEND: begin
            new_key_nxt = alu_res.step;
            pos_nxt     = '0;
            idx_nxt     = last_addr;
            state_nxt   = S_SHIFT;
          end
          FN_APPEND: begin
            new_key_nxt = alu_res.step;
            pos_nxt     = ADDR_BITS'(occ_r);
            state_nxt   = S_WRITE;
          end
          FN_SORTED: begin
            new_key_nxt = key_r;
            if (alu_res.below) begin
              pos_nxt   = idx_r;
              idx_nxt   = last_addr;
              state_nxt = S_SHIFT;
            end else if (scan_last) begin
              pos_nxt   = ADDR_BITS'(occ_r);
              state_nxt = S_WRITE;
            end else begin
              idx_nxt = idx_r + ADDR_BITS'(1);
            end
          end
          FN_REM_FIRST, FN_REM_KEY: begin
            if ((func_r == FN_REM_FIRST) || alu_res.equal) begin
              item_out_nxt = rd_item;
              key_out_nxt  = rd_key;
              status_nxt   = ST_OK;
              pos_nxt      = idx_r;
              if (scan_last) begin
                occ_nxt   = occ_r - COUNT_BITS'(1);
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = idx_r + ADDR_BITS'(1);
                state_nxt = S_SHIFT;
              end
            end else if (scan_last) begin
              status_nxt = ST_MISS;
              state_nxt  = S_DONE;
            end else begin
              idx_nxt = idx_r + ADDR_BITS'(1);
            end
          end
          default: begin
            status_nxt = ST_MISS;
            state_nxt  = S_DONE;
          end
        endcase
      end

      S_SHIFT: begin
        ram_wr_en = 1'b1;
        if (is_insert) begin
          // Open a slot: move entries up, from the tail down to the position.
          ram_wr_addr = idx_r + ADDR_BITS'(1);
          if (idx_r == pos_r) begin
            state_nxt = S_WRITE;
          end else begin
            idx_nxt = idx_r - ADDR_BITS'(1);
          end
        end else begin
          // Close the slot: move entries down, from the position up to the tail.
          ram_wr_addr = idx_r - ADDR_BITS'(1);
          if (scan_last) begin
            occ_nxt   = occ_r - COUNT_BITS'(1);
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + ADDR_BITS'(1);
          end
        end
      end

      S_WRITE: begin
        ram_wr_en    = 1'b1;
        ram_wr_addr  = pos_r;
        ram_wr_data  = {new_key_r, item_r};
        occ_nxt      = occ_r + COUNT_BITS'(1);
        status_nxt   = ST_OK;
        item_out_nxt = '0;
        key_out_nxt  = new_key_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      occ_r      <= '0;
      base_key_r <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (cfg_wr_en) begin
        base_key_r <= cfg_wr_data;
      end
    end
  end

  // Request, working and result registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    item_r     <= item_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    new_key_r  <= new_key_nxt;
    status_r   <= status_nxt;
    item_out_r <= item_out_nxt;
    key_out_r  <= key_out_nxt;
  end

  // Result word.
  assign out_tvalid = (state_r == S_DONE);
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_DATA_BITS'({occ_r, key_out_r, item_out_r});

  // The block never takes a request while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("request taken while a result is pending");

  // The entry count never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= COUNT_BITS'(CAPACITY))
    else $error("entry count beyond capacity");

  // The entry RAM is written only while moving entries or placing a new one.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_SHIFT || state_r == S_WRITE))
    else $error("entry write outside move or place phase");

  // A change of the entry count comes together with a result.
  a_occ_result: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |-> out_tvalid)
    else $error("entry count changed without a result");

  // A rejected insert is only reported on a full list.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_FULL) |-> (occ_r == COUNT_BITS'(CAPACITY)))
    else $error("full status on a list that is not full");

endmodule

`default_nettype wire

/* src/skpl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skpl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/skpl_key_alu.sv */
// Shared key unit: one incrementer/decrementer and one signed comparator.
`default_nettype none

module skpl_key_alu
  import skpl_pkg::*;
(
  input  wire logic [KEY_BITS-1:0] entry_key,
  input  wire logic [KEY_BITS-1:0] req_key,
  input  wire logic                dec,
  output alu_res_t                 res
);

  logic [KEY_BITS-1:0] delta;

  // Step by minus one for prepend, plus one otherwise; keys wrap.
  assign delta     = dec ? {KEY_BITS{1'b1}} : KEY_BITS'(1);
  assign res.step  = entry_key + delta;

  // Signed compare of the request key against the stored key.
  assign res.below = $signed(req_key) < $signed(entry_key);
  assign res.equal = (req_key == entry_key);

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the sorted key priority list with its own list predictor.
`timescale 1ns / 100ps

module tb_top
  import skpl_pkg::*;
;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PAD_LSB     = ITEM_BITS + KEY_BITS + COUNT_BITS;

  // One result word, split into its fields.
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ITEM_BITS-1:0]   item;
    logic [KEY_BITS-1:0]    key;
    logic [COUNT_BITS-1:0]  count;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [FUNC_BITS-1:0]     in_tuser = '0;      // [2:0] func
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;      // [31:0] item_in, [63:32] key_in
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [STATUS_BITS-1:0]   out_tuser;          // [1:0] status
  logic [OUT_DATA_BITS-1:0] out_tdata;          // [31:0] item_out, [63:32] key_out,
                                                // [68:64] entry_count, rest zero
  logic                     cfg_wr_en = 1'b0;
  logic [KEY_BITS-1:0]      cfg_wr_data = '0;   // base_key

  // Predicted list contents, head at index 0.
  logic [KEY_BITS-1:0]  list_keys [CAPACITY];
  logic [ITEM_BITS-1:0] list_items [CAPACITY];
  int                   list_fill = 0;
  logic [KEY_BITS-1:0]  base_key_model = '0;

  list_result_t pending_results [$];

  bit valid_drv = 1'b0;
  int burst_left = 0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int status_ok_seen = 0;
  int status_miss_seen = 0;
  int status_full_seen = 0;
  int base_key_writes = 0;
  int cycle_count = 0;

  sorted_key_priority_list uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit; a hung block ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_key_priority_list regression: fail");
    $finish;
  end

  // Close the gap left by a removed entry.
  function automatic void drop_entry(input int at);
    int i;
    for (i = at; i < list_fill - 1; i++) begin
      list_keys[i]  = list_keys[i+1];
      list_items[i] = list_items[i+1];
    end
    list_fill--;
  endfunction

  // Apply one request to the predicted list and return the word it must produce.
  function automatic list_result_t predict_request(input logic [FUNC_BITS-1:0] fn,
                                                   input logic [ITEM_BITS-1:0] item,
                                                   input logic [KEY_BITS-1:0]  key);
    list_result_t res;
    logic [KEY_BITS-1:0] new_key;
    int slot;
    int i;
    bit hit;
    res.status = ST_MISS;
    res.item   = '0;
    res.key    = '0;
    slot       = 0;
    hit        = 1'b0;
    new_key    = '0;
    case (fn)
      FN_PREPEND, FN_APPEND, FN_SORTED: begin
        if (list_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (fn == FN_PREPEND) begin
            new_key = (list_fill != 0) ? list_keys[0] - 1'b1 : base_key_model;
            slot    = 0;
          end else if (fn == FN_APPEND) begin
            new_key = (list_fill != 0) ? list_keys[list_fill-1] + 1'b1 : base_key_model;
            slot    = list_fill;
          end else begin
            // New entry goes before the first entry with a larger signed key, else at the tail.
            new_key = key;
            slot    = list_fill;
            for (i = 0; i < list_fill && !hit; i++) begin
              if ($signed(key) < $signed(list_keys[i])) begin
                slot = i;
                hit  = 1'b1;
              end
            end
          end
          for (i = list_fill; i > slot; i--) begin
            list_keys[i]  = list_keys[i-1];
            list_items[i] = list_items[i-1];
          end
          list_keys[slot]  = new_key;
          list_items[slot] = item;
          list_fill++;
          res.status = ST_OK;
          res.key    = new_key;
        end
      end
      FN_REM_FIRST: begin
        if (list_fill > 0) begin
          res.status = ST_OK;
          res.item   = list_items[0];
          res.key    = list_keys[0];
          drop_entry(0);
        end
      end
      FN_REM_KEY: begin
        // Only the earliest entry with the key goes.
        for (i = 0; i < list_fill && !hit; i++) begin
          if (list_keys[i] == key) begin
            res.status = ST_OK;
            res.item   = list_items[i];
            res.key    = list_keys[i];
            drop_entry(i);
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.count = COUNT_BITS'(list_fill);
    return res;
  endfunction

  // Keys partly random, partly clustered at the extremes and near zero, so that duplicates turn up often.
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return 32'h8000_0000 + $urandom_range(0, 3);
      3:       return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return 32'($urandom_range(0, 15)) - 32'd8;
    endcase
  endfunction

  task automatic set_valid(input bit v);
    if (valid_drv != v) begin
      valid_drv = v;
      in_tvalid <= v;
    end
  endtask

  // Send one request word, record its prediction, then idle as the burst pattern says.
  task automatic send_word(input logic [FUNC_BITS-1:0] fn,
                           input logic [ITEM_BITS-1:0] item,
                           input logic [KEY_BITS-1:0]  key);
    int gap;
    in_tuser <= fn;
    in_tdata <= {key, item};
    set_valid(1'b1);
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(predict_request(fn, item, key));
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        set_valid(1'b0);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic wait_results_done(input int settle);
    set_valid(1'b0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_base_key(input logic [KEY_BITS-1:0] value);
    wait_results_done(4);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_key_model = value;
    base_key_writes++;
  endtask

  // One random request; insert_pct sets the share of inserts.
  task automatic send_random(input int insert_pct);
    logic [FUNC_BITS-1:0] fn;
    logic [KEY_BITS-1:0]  key;
    if ($urandom_range(0, 99) < insert_pct) begin
      fn = FUNC_BITS'($urandom_range(0, 2));
    end else if ($urandom_range(0, 19) == 0) begin
      fn = FUNC_BITS'($urandom_range(5, 7));
    end else begin
      fn = $urandom_range(0, 1) ? FN_REM_FIRST : FN_REM_KEY;
    end
    if (fn == FN_REM_KEY && list_fill > 0 && $urandom_range(0, 3) != 0) begin
      key = list_keys[$urandom_range(0, list_fill - 1)];
    end else begin
      key = pick_key();
    end
    send_word(fn, $urandom, key);
  endtask

  // Removes and undefined codes on an empty list.
  task automatic test_empty_list();
    send_word(FN_REM_FIRST, 32'h1234_5678, 32'h0);
    send_word(FN_REM_KEY, 32'hffff_ffff, 32'h0);
    send_word(FUNC_BITS'(5), 32'hffff_ffff, 32'hffff_ffff);
    send_word(FUNC_BITS'(6), 32'h0, 32'h8000_0000);
    send_word(FUNC_BITS'(7), 32'ha5a5_a5a5, 32'h7fff_ffff);
  endtask

  // Key wrap at the signed limits, sorted insert at both ends and duplicate keys.
  task automatic test_key_wrap();
    write_base_key(32'h7fff_ffff);
    send_word(FN_PREPEND, 32'h0000_0001, 32'h0);
    send_word(FN_APPEND, 32'h0000_0002, 32'h0);
    send_word(FN_PREPEND, 32'h0000_0003, 32'h0);
    send_word(FN_SORTED, 32'hffff_ffff, 32'h8000_0000);
    send_word(FN_SORTED, 32'h0000_0000, 32'h7fff_ffff);
    send_word(FN_SORTED, 32'h5555_aaaa, 32'h7fff_fffe);
    send_word(FN_REM_KEY, 32'h0, 32'h7fff_ffff);
    send_word(FN_REM_KEY, 32'h0, 32'd12345);
    send_word(FN_REM_FIRST, 32'h0, 32'h0);
  endtask

  // Fill to capacity, then every insert must be turned away.
  task automatic test_full_list();
    while (list_fill < CAPACITY) send_word(FN_APPEND, $urandom, 32'h0);
    send_word(FN_PREPEND, 32'hdead_beef, 32'h0);
    send_word(FN_APPEND, 32'hdead_beef, 32'h0);
    send_word(FN_SORTED, 32'hdead_beef, 32'h0);
    send_word(FN_REM_FIRST, 32'h0, 32'h0);
  endtask

  // Rounds that fill the list past full and then empty it past empty.
  task automatic test_fill_and_drain(input int rounds);
    int r;
    int guard;
    for (r = 0; r < rounds; r++) begin
      guard = 0;
      while (list_fill < CAPACITY && guard < 200) begin
        send_random(85);
        guard++;
      end
      repeat ($urandom_range(1, 3)) send_random(100);
      while (list_fill > 0 && guard < 400) begin
        send_random(10);
        guard++;
      end
      repeat ($urandom_range(1, 2)) send_random(0);
    end
  endtask

  // Free-running mix with the occasional full pause of the sender.
  task automatic test_mixed_traffic(input int words, input int insert_pct);
    int n;
    for (n = 0; n < words; n++) begin
      send_random(insert_pct);
      if ($urandom_range(0, 149) == 0) wait_results_done(2);
    end
  endtask

  // Receiver backpressure: a randomly chosen mode, changed after each random span.
  initial begin : ready_pattern
    int mode;
    int span;
    int hold;
    int phase;
    bit rdy;
    hold  = 0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(100, 600);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: begin
            rdy   = (phase % 5) < 3;
            phase++;
          end
          default: begin
            if (hold > 0) begin
              hold--;
              rdy = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              hold = $urandom_range(8, 24);
              rdy  = 1'b0;
            end else begin
              rdy = 1'b1;
            end
          end
        endcase
        out_tready <= rdy;
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch in %s of result %0d: expected %h, got %h",
               field, results_seen, want, got);
    end
  endtask

  // Compare every result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Result word with no request outstanding: status %h data %h",
                   out_tuser, out_tdata);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_tuser));
        if (out_tdata[ITEM_BITS-1:0] !== want.item)
          report_mismatch("item_out", 64'(want.item), 64'(out_tdata[ITEM_BITS-1:0]));
        if (out_tdata[ITEM_BITS +: KEY_BITS] !== want.key)
          report_mismatch("key_out", 64'(want.key), 64'(out_tdata[ITEM_BITS +: KEY_BITS]));
        if (out_tdata[ITEM_BITS+KEY_BITS +: COUNT_BITS] !== want.count)
          report_mismatch("entry_count", 64'(want.count),
                          64'(out_tdata[ITEM_BITS+KEY_BITS +: COUNT_BITS]));
        if (out_tdata[OUT_DATA_BITS-1:PAD_LSB] !== '0)
          report_mismatch("padding", 64'h0, 64'(out_tdata[OUT_DATA_BITS-1:PAD_LSB]));
        case (want.status)
          ST_OK:   status_ok_seen++;
          ST_FULL: status_full_seen++;
          default: status_miss_seen++;
        endcase
      end
      results_seen++;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_key_wrap();
    test_full_list();

    write_base_key(32'h8000_0000);
    test_fill_and_drain(8);
    write_base_key(32'hffff_ffff);
    test_mixed_traffic(850, 50);
    write_base_key($urandom);
    test_fill_and_drain(6);
    write_base_key(32'h0000_0000);
    test_mixed_traffic(120, 25);

    wait_results_done(40);

    $display("Sent %0d request words over %0d base key settings; %0d results checked.",
             words_sent, base_key_writes, results_seen);
    $display("Result status seen: %0d ok, %0d empty or not found, %0d full; %0d mismatches.",
             status_ok_seen, status_miss_seen, status_full_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sorted_key_priority_list regression: pass");
    end else begin
      $display("sorted_key_priority_list regression: fail");
    end
    $finish;
  end

endmodule
